// ----- rtl/fscp_pkg.sv -----
// ----------------------------------------------------------------------------
// fscp_pkg: shared types and constants
// Character codes, field widths and result type for the framed step parser.
// ----------------------------------------------------------------------------
package fscp_pkg;

  localparam int BufferChars = 64;
  localparam int PosWidth    = $clog2(BufferChars);
  localparam int ValueWidth  = 28;
  localparam int NumFields   = 4;
  localparam int FieldChars  = 8;
  localparam int FirstField  = 2;

  localparam logic [7:0] CharStart = 8'h3C;  // '<'
  localparam logic [7:0] CharEnd   = 8'h3E;  // '>'
  localparam logic [7:0] CharStep  = 8'h53;  // 'S'
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;

  localparam logic STATUS_STEP    = 1'b0;
  localparam logic STATUS_UNKNOWN = 1'b1;

  typedef enum logic [1:0] {
    PH_LEADING,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef logic signed [ValueWidth-1:0] value_t;

  typedef struct packed {
    logic   status;
    value_t radial_step_goal;
    value_t radial_timer_count;
    value_t angular_step_goal;
    value_t angular_timer_count;
  } result_t;

endpackage

// ----- rtl/framed_step_command_parser_top.sv -----
// A taken '>' request writes its result to the output register, or to skid while stalled.
// Throughput: one byte per cycle while in_stall_o is low; all parse state is updated in
// the cycle of the request. A two-entry output (result register plus skid register) lets
// input continue while a result waits; input stalls only when both entries are full.
// Reset: rst_ni asynchronous active low clears frame state, field values and valid flags.
// ----------------------------------------------------------------------------
// framed_step_command_parser_top
// Parses '<'...'>' framed ASCII step commands into four signed decimal fields.
// ----------------------------------------------------------------------------
module framed_step_command_parser_top
  import fscp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic [7:0]   rx_byte_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output logic         status_o,
  output value_t       radial_step_goal_o,
  output value_t       radial_timer_count_o,
  output value_t       angular_step_goal_o,
  output value_t       angular_timer_count_o
);

  logic                in_frame_q, in_frame_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic                is_step_q, is_step_d;
  logic [2:0]          field_q, field_d;
  logic [3:0]          chars_q, chars_d;
  logic                skip_q, skip_d;
  phase_e              phase_q, phase_d;
  logic                neg_q, neg_d;
  value_t              vals_q [NumFields];
  value_t              vals_d [NumFields];

  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;
  logic    accept, new_res, out_free;

  logic [1:0] idx;
  logic       is_digit, is_ws, is_sign;
  value_t     digit, cur_val;

  assign accept   = in_valid_i && !in_stall_o;
  assign idx      = field_q[1:0];
  assign is_digit = (rx_byte_i >= CharZero) && (rx_byte_i <= CharNine);
  assign is_ws    = (rx_byte_i >= CharTab) && (rx_byte_i <= CharCr);
  assign is_sign  = (rx_byte_i == CharMinus) || (rx_byte_i == CharPlus);
  assign digit    = value_t'(rx_byte_i - CharZero);
  assign cur_val  = vals_q[idx];

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    is_step_d  = is_step_q;
    field_d    = field_q;
    chars_d    = chars_q;
    skip_d     = skip_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    vals_d     = vals_q;
    new_res    = 1'b0;
    if (accept) begin
      if (!in_frame_q) begin
        if (rx_byte_i == CharStart) begin
          in_frame_d = 1'b1;
          pos_d      = '0;
          is_step_d  = 1'b0;
          field_d    = '0;
          chars_d    = '0;
          skip_d     = 1'b0;
          phase_d    = PH_LEADING;
          neg_d      = 1'b0;
          for (int k = 0; k < NumFields; k++) vals_d[k] = '0;
        end
      end else if (rx_byte_i != CharEnd) begin
        if (pos_q < PosWidth'(BufferChars - 1)) begin
          pos_d = pos_q + 1'b1;
          if (pos_q == '0) begin
            is_step_d = (rx_byte_i == CharStep);
          end else if (pos_q < PosWidth'(FirstField) || !is_step_q ||
                       field_q >= 3'(NumFields)) begin
            // nothing to parse
          end else if (skip_q) begin
            skip_d = 1'b0;
          end else if (rx_byte_i == CharSpace) begin
            field_d = field_q + 1'b1;
            chars_d = '0;
            phase_d = PH_LEADING;
            neg_d   = 1'b0;
          end else begin
            // atol-style conversion of one character
            if (phase_q == PH_LEADING && is_sign) begin
              neg_d   = (rx_byte_i == CharMinus);
              phase_d = PH_DIGITS;
            end else if ((phase_q == PH_LEADING && !is_ws) || phase_q == PH_DIGITS) begin
              if (is_digit) begin
                phase_d     = PH_DIGITS;
                vals_d[idx] = (cur_val <<< 3) + (cur_val <<< 1) + (neg_q ? -digit : digit);
              end else begin
                phase_d = PH_DONE;
              end
            end
            chars_d = chars_q + 1'b1;
            if (chars_q == 4'(FieldChars - 1)) begin
              field_d = field_q + 1'b1;
              chars_d = '0;
              phase_d = PH_LEADING;
              neg_d   = 1'b0;
              skip_d  = 1'b1;
            end
          end
        end
      end else begin
        in_frame_d = 1'b0;
        new_res    = 1'b1;
      end
    end
  end

  always_comb begin
    if (is_step_q) begin
      res.status              = STATUS_STEP;
      res.radial_step_goal    = vals_q[0];
      res.radial_timer_count  = vals_q[1];
      res.angular_step_goal   = vals_q[2];
      res.angular_timer_count = vals_q[3];
    end else begin
      res.status              = STATUS_UNKNOWN;
      res.radial_step_goal    = '0;
      res.radial_timer_count  = '0;
      res.angular_step_goal   = '0;
      res.angular_timer_count = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      is_step_q  <= 1'b0;
      field_q    <= '0;
      chars_q    <= '0;
      skip_q     <= 1'b0;
      phase_q    <= PH_LEADING;
      neg_q      <= 1'b0;
      for (int k = 0; k < NumFields; k++) vals_q[k] <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      is_step_q  <= is_step_d;
      field_q    <= field_d;
      chars_q    <= chars_d;
      skip_q     <= skip_d;
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      vals_q     <= vals_d;
    end
  end

  // output register with one skid entry behind it
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || new_res;
      skid_valid_q <= skid_valid_q && new_res;
    end else if (new_res) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
        if (new_res) skid_q <= res;
      end else if (new_res) begin
        out_q <= res;
      end
    end else if (new_res) begin
      skid_q <= res;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign status_o              = out_q.status;
  assign radial_step_goal_o    = out_q.radial_step_goal;
  assign radial_timer_count_o  = out_q.radial_timer_count;
  assign angular_step_goal_o   = out_q.angular_step_goal;
  assign angular_timer_count_o = out_q.angular_timer_count;

endmodule

// ----- rtl/fscp_checker.sv -----
// ----------------------------------------------------------------------------
// fscp_checker
// Port-level checks for the framed step parser, bound to the top level.
// ----------------------------------------------------------------------------
module fscp_checker
  import fscp_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] rx_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       status_o,
  input value_t     radial_step_goal_o,
  input value_t     radial_timer_count_o,
  input value_t     angular_step_goal_o,
  input value_t     angular_timer_count_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // unknown command carries zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STATUS_UNKNOWN |->
      radial_step_goal_o == '0 && radial_timer_count_o == '0 &&
      angular_step_goal_o == '0 && angular_timer_count_o == '0)
    else $error("unknown command with nonzero fields");

  // input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && $past(out_valid_o))
    else $error("input stalled with empty output");

  // a fresh result follows an end marker request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |->
      $past(in_valid_i && !in_stall_o && rx_byte_i == CharEnd))
    else $error("result without end marker");

endmodule

bind framed_step_command_parser_top fscp_checker u_fscp_checker (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: framed step command parser
// Streams framed and unframed bytes into the parser with random gaps and
// output stalls, predicts every result in a scoreboard and checks each field.
// ----------------------------------------------------------------------------
module testbench;
  import fscp_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomBytes = 2000;
  localparam int QuietTail   = 200;
  localparam int DrainCycles = 10;
  localparam int MaxReported = 10;

  localparam logic [7:0] CharNul = 8'h00;

  // --------------------------------------------------------------------------
  // scoreboard: tracks frame parse state and holds the commands still due
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    result_t     pending_commands[$];
    int          mismatches;
    bit          in_frame;
    int unsigned frame_pos;
    bit          is_step;
    int unsigned field_no;
    int unsigned field_chars;
    bit          skip_byte;
    phase_e      phase;
    bit          negative;
    int          field_val[NumFields];

    function new();
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_field();
      field_chars = 0;
      phase       = PH_LEADING;
      negative    = 1'b0;
    endfunction

    function void close_field();
      field_no++;
      clear_field();
    endfunction

    function void clear_frame();
      in_frame  = 1'b0;
      frame_pos = 0;
      is_step   = 1'b0;
      field_no  = 0;
      skip_byte = 1'b0;
      clear_field();
      foreach (field_val[k]) field_val[k] = 0;
    endfunction

    // advance the parse by one accepted request byte
    function void note_request(logic [7:0] c);
      result_t want;
      bit      take;
      int      d;
      if (!in_frame) begin
        if (c == CharStart) begin
          clear_frame();
          in_frame = 1'b1;
        end
      end else if (c != CharEnd) begin
        if (frame_pos < BufferChars - 1) begin
          if (frame_pos == 0) begin
            is_step = (c == CharStep);
          end else if (frame_pos >= FirstField && is_step && field_no < NumFields) begin
            if (skip_byte) begin
              skip_byte = 1'b0;
            end else if (c == CharSpace) begin
              close_field();
            end else begin
              take = 1'b1;
              if (phase == PH_LEADING) begin
                if (c >= CharTab && c <= CharCr) begin
                  take = 1'b0;
                end else if (c == CharMinus || c == CharPlus) begin
                  negative = (c == CharMinus);
                  phase    = PH_DIGITS;
                  take     = 1'b0;
                end else begin
                  phase = PH_DIGITS;
                end
              end
              if (take && phase == PH_DIGITS) begin
                if (c >= CharZero && c <= CharNine) begin
                  d = int'(c - CharZero);
                  field_val[field_no] = field_val[field_no] * 10 + (negative ? -d : d);
                end else begin
                  phase = PH_DONE;
                end
              end
              field_chars++;
              // a full field swallows the byte after it
              if (field_chars >= FieldChars) begin
                close_field();
                skip_byte = 1'b1;
              end
            end
          end
          frame_pos++;
        end
      end else begin
        in_frame = 1'b0;
        want     = '0;
        if (is_step) begin
          want.status              = STATUS_STEP;
          want.radial_step_goal    = field_val[0][ValueWidth-1:0];
          want.radial_timer_count  = field_val[1][ValueWidth-1:0];
          want.angular_step_goal   = field_val[2][ValueWidth-1:0];
          want.angular_timer_count = field_val[3][ValueWidth-1:0];
        end else begin
          want.status = STATUS_UNKNOWN;
        end
        pending_commands.push_back(want);
      end
    endfunction

    function void note_mismatch(string what, result_t want, result_t got);
      mismatches++;
      if (mismatches <= MaxReported) begin
        $display("%s: expected %0d / %0d %0d %0d %0d, got %0d / %0d %0d %0d %0d", what,
                 want.status, $signed(want.radial_step_goal),
                 $signed(want.radial_timer_count), $signed(want.angular_step_goal),
                 $signed(want.angular_timer_count), got.status,
                 $signed(got.radial_step_goal), $signed(got.radial_timer_count),
                 $signed(got.angular_step_goal), $signed(got.angular_timer_count));
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_commands.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
        return;
      end
      want = pending_commands.pop_front();
      if (got.status !== want.status ||
          got.radial_step_goal !== want.radial_step_goal ||
          got.radial_timer_count !== want.radial_timer_count ||
          got.angular_step_goal !== want.angular_step_goal ||
          got.angular_timer_count !== want.angular_timer_count) begin
        note_mismatch("result mismatch", want, got);
      end
    endfunction
  endclass

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   [7:0] rx_byte_i = '0;
  logic   out_stall_i = 1'b0;
  logic   in_stall_o;
  logic   out_valid_o;
  logic   status_o;
  value_t radial_step_goal_o;
  value_t radial_timer_count_o;
  value_t angular_step_goal_o;
  value_t angular_timer_count_o;

  frame_scoreboard sb;
  logic [7:0]      stream_bytes[$];
  bit              quiet        = 1'b0;
  int              in_idle_pct  = 10;
  int              out_idle_pct = 10;
  int              out_hold     = 0;
  int              cycle_count  = 0;

  framed_step_command_parser_top u_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .rx_byte_i             (rx_byte_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .status_o              (status_o),
    .radial_step_goal_o    (radial_step_goal_o),
    .radial_timer_count_o  (radial_timer_count_o),
    .angular_step_goal_o   (angular_step_goal_o),
    .angular_timer_count_o (angular_timer_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // output stall bursts
  always @(posedge clk_i) begin
    if (out_hold > 0) begin
      out_hold--;
    end else if (!quiet && $urandom_range(0, 99) < out_idle_pct) begin
      out_hold = $urandom_range(1, 18);
    end
    out_stall_i <= (out_hold > 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(result_t'({status_o, radial_step_goal_o, radial_timer_count_o,
                                 angular_step_goal_o, angular_timer_count_o}));
    end
  end

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) stream_bytes.push_back(s[i]);
  endfunction

  // any byte except the end marker
  function automatic logic [7:0] pick_content();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == CharEnd) b = CharSpace;
    return b;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 99) < in_idle_pct) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(b);
  endtask

  initial begin : stimulus
    int         directed_count;
    int         sel;
    int         nfields;
    int         len;
    int         ndig;
    logic [7:0] b;

    sb = new();

    push_text("<S 1 2 3 4>");
    push_text("<S 99999999 -9999999 +0000000 00000000>");
    push_text("<S 12345678x9 7 -0 3>");
    push_text("<>");
    push_text("<X 1 2 3 4>");
    push_text("<S>");
    push_text("<S1>");
    push_text("<S 5>");
    push_text("<S \t-12 \r\n+7 - +>");
    push_text("<S <3 1a5 2 9 8 7 6>");
    push_text("<<1 2>");
    push_text("<S 12");
    stream_bytes.push_back(CharNul);
    push_text("34 5>");
    // junk outside any frame, the end marker included
    stream_bytes.push_back(8'hFF);
    stream_bytes.push_back(CharNul);
    push_text("> S 7");
    push_text("<S 1 2 3 44>");
    // overlong frame, content past the buffer is dropped
    push_text("<S ");
    repeat (70) stream_bytes.push_back(CharZero + 8'd1);
    stream_bytes.push_back(CharEnd);
    directed_count = stream_bytes.size();

    while (stream_bytes.size() < directed_count + RandomBytes) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        stream_bytes.push_back(CharStart);
        stream_bytes.push_back(($urandom_range(0, 19) != 0) ? CharStep : pick_content());
        stream_bytes.push_back(($urandom_range(0, 3) != 0) ? CharSpace : pick_content());
        nfields = $urandom_range(0, 6);
        for (int k = 0; k < nfields; k++) begin
          len = 0;
          if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
              stream_bytes.push_back(CharTab + 8'($urandom_range(0, 4)));
              len++;
            end
          end
          if ($urandom_range(0, 2) == 0) begin
            stream_bytes.push_back($urandom_range(0, 1) ? CharMinus : CharPlus);
            len++;
          end
          ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10)
                                             : $urandom_range(0, FieldChars - len);
          repeat (ndig) stream_bytes.push_back(CharZero + 8'($urandom_range(0, 9)));
          if ($urandom_range(0, 7) == 0) stream_bytes.push_back(pick_content());
          stream_bytes.push_back(($urandom_range(0, 7) == 0) ? pick_content() : CharSpace);
        end
        stream_bytes.push_back(CharEnd);
      end else if (sel < 90) begin
        stream_bytes.push_back(CharStart);
        repeat ($urandom_range(0, 12)) stream_bytes.push_back(pick_content());
        stream_bytes.push_back(CharEnd);
      end else if (sel < 93) begin
        stream_bytes.push_back(CharStart);
        stream_bytes.push_back(CharStep);
        repeat ($urandom_range(60, 90)) begin
          b = ($urandom_range(0, 4) == 0) ? CharSpace
                                          : CharZero + 8'($urandom_range(0, 9));
          stream_bytes.push_back(b);
        end
        stream_bytes.push_back(CharEnd);
      end else begin
        // noise between frames
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom_range(0, 255));
          if (b != CharStart) stream_bytes.push_back(b);
        end
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < stream_bytes.size(); i++) begin
      quiet = (i >= stream_bytes.size() - QuietTail);
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: in_idle_pct = 0;
          1: in_idle_pct = 5;
          2: in_idle_pct = 15;
          default: in_idle_pct = 30;
        endcase
        case ($urandom_range(0, 3))
          0: out_idle_pct = 0;
          1: out_idle_pct = 5;
          2: out_idle_pct = 15;
          default: out_idle_pct = 30;
        endcase
      end
      send_byte(stream_bytes[i]);
    end
    in_valid_i <= 1'b0;

    while (sb.pending_commands.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_commands.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
